### rtl/sine_commutation_pwm_assert.svh
// Assertion macros for the sine commutation PWM block.
// Needs nothing else; taken in by `include in the files that carry checks.
`ifndef SINE_COMMUTATION_PWM_ASSERT_SVH
`define SINE_COMMUTATION_PWM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sine_commutation_pwm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sine_commutation_pwm: next-cycle check failed");

`endif

### rtl/scp_pkg.sv
// Shared types and constants of the sine commutation PWM block.
// Used by the channel interfaces, the sine store and the top level.
package scp_pkg;

    // Sine store geometry.
    localparam int TABLE_SIZE     = 256;
    localparam int ADDR_W         = $clog2(TABLE_SIZE);
    localparam int ENTRY_W        = 11;

    // Encoder and PWM scaling.
    localparam int ENCODER_COUNTS = 4096;
    localparam int ANGLE_W        = 12;
    localparam int POLE_W         = 7;
    localparam int PROD_W         = ANGLE_W + POLE_W;
    // Electrical index is angle * poles * TABLE_SIZE / (2 * ENCODER_COUNTS).
    localparam int ANGLE_SHIFT    = $clog2((2 * ENCODER_COUNTS) / TABLE_SIZE);
    localparam int PWM_FULL       = 1024;
    localparam int SINE_PEAK      = 1024;
    localparam int PEAK_SHIFT     = $clog2(SINE_PEAK);
    localparam int DUTY_W         = 10;
    localparam int TORQUE_IN_W    = 16;
    localparam int TQ_W           = $clog2(PWM_FULL) + 2;

    // Phase offsets, all modulo the table size.
    localparam int SHIFT_FWD      = ((3 * TABLE_SIZE) / 4) % TABLE_SIZE;
    localparam int SHIFT_BACK     = (TABLE_SIZE - SHIFT_FWD) % TABLE_SIZE;
    localparam int THIRD          = TABLE_SIZE / 3;
    localparam int TWO_THIRDS     = 2 * (TABLE_SIZE / 3);

    localparam logic [POLE_W-1:0] POLE_RESET = 7'd14;

    // Request codes.
    localparam logic REQ_COMMUTATE = 1'b0;
    localparam logic REQ_WRITE     = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic signed [TORQUE_IN_W-1:0] drive_torque;
        logic [ANGLE_W-1:0]            shaft_angle;
        logic                          brake_hold;
        logic                          swap_phases;
        logic [ADDR_W-1:0]             table_index;
        logic [ENTRY_W-1:0]            table_entry;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] phase_one_duty;
        logic [DUTY_W-1:0] phase_two_duty;
        logic [DUTY_W-1:0] phase_three_duty;
    } t_duty;

endpackage

### rtl/scp_cmd_if.sv
// Command channel: valid/ready handshake carrying one command word.
// Depends on scp_pkg for the payload type.
interface scp_cmd_if;
    logic             valid;
    logic             ready;
    scp_pkg::t_cmd    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/scp_duty_if.sv
// Duty channel: valid/ready handshake carrying three phase compare values.
// Depends on scp_pkg for the payload type.
interface scp_duty_if;
    logic             valid;
    logic             ready;
    scp_pkg::t_duty   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/scp_sine_ram.sv
// One copy of the sine store: one write port, one registered read port.
// Depends on scp_pkg for the table geometry.
module scp_sine_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [scp_pkg::ADDR_W-1:0]     i_waddr,
    input  logic [scp_pkg::ENTRY_W-1:0]    i_wdata,
    input  logic                           i_re,
    input  logic [scp_pkg::ADDR_W-1:0]     i_raddr,
    output logic [scp_pkg::ENTRY_W-1:0]    o_rdata
);
    import scp_pkg::*;

    logic [ENTRY_W-1:0] r_mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held while the reading stage is stalled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/sine_commutation_pwm.sv
// Sinusoidal three-phase commutation with a writable sine store. Each command
// word is either a store write or a commutation request; a commutation
// request gives one word of three PWM duties, a store write gives none. The
// block takes one word every clock cycle unless the duty channel holds it up,
// and a commutation result passes through four register stages on its way to
// the duty channel, the first stage loaded at the accepting edge:
// operand capture with the angle-by-pole multiply, index arithmetic, the store
// read (three copies of the store, one per phase, each with a registered
// read), and the torque scaling with clipping. Each stage holds its word only
// while the stage after it is full and stalled, so bubbles close up and new
// words keep entering behind a waiting result until all four stages are full.
// Store entries read before they were written give undefined duties. The pole
// count register may be written only while no command is in flight.
`include "sine_commutation_pwm_assert.svh"

module sine_commutation_pwm (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [scp_pkg::POLE_W-1:0]   i_cfg_data,
    scp_cmd_if.sink                      i_cmd,
    scp_duty_if.source                   o_duty
);
    import scp_pkg::*;

    // Signed torque times a sine value, divided by the peak with truncation
    // and clipped into the duty range.
    function automatic logic [DUTY_W-1:0] scale_duty(
        input logic [ENTRY_W-1:0]    s,
        input logic signed [TQ_W-1:0] t
    );
        logic signed [ENTRY_W+TQ_W:0] p;
        logic [ENTRY_W+TQ_W-PEAK_SHIFT:0] q;
        p = $signed({1'b0, s}) * t;
        q = p[ENTRY_W+TQ_W:PEAK_SHIFT];
        if (p <= 0) begin
            scale_duty = '0;
        end else if (q > (ENTRY_W+TQ_W-PEAK_SHIFT+1)'(PWM_FULL - 1)) begin
            scale_duty = DUTY_W'(PWM_FULL - 1);
        end else begin
            scale_duty = DUTY_W'(q);
        end
    endfunction

    localparam logic signed [TORQUE_IN_W-1:0] TQ_MAX = TORQUE_IN_W'(PWM_FULL);
    localparam logic signed [TORQUE_IN_W-1:0] TQ_MIN = -TORQUE_IN_W'(PWM_FULL);

    // Pole count register.
    logic [POLE_W-1:0] r_pole_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_count <= POLE_RESET;
        end else if (i_cfg_we) begin
            r_pole_count <= i_cfg_data;
        end
    end

    // Stage enables: a stage loads when it is empty or its contents move on.
    logic en_a, en_b, en_c, en_d;

    logic                    r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic                    r_a_req, r_b_req;
    logic signed [TQ_W-1:0]  r_a_torque, r_b_torque, r_c_torque;
    logic [PROD_W-1:0]       r_a_prod;
    logic                    r_a_brake;
    logic                    r_a_swap, r_b_swap, r_c_swap;
    logic [ADDR_W-1:0]       r_a_widx, r_b_widx;
    logic [ENTRY_W-1:0]      r_a_wdata, r_b_wdata;
    logic [ADDR_W-1:0]       r_b_addr_a, r_b_addr_b, r_b_addr_c;
    t_duty                   r_d_duty;

    assign en_d = !r_d_vld || o_duty.ready;
    assign en_c = !r_c_vld || en_d;
    assign en_b = !r_b_vld || en_c;
    assign en_a = !r_a_vld || en_b;

    assign i_cmd.ready = en_a;

    // Stage A: clip the torque and multiply angle by pole count.
    logic signed [TQ_W-1:0] n_a_torque;

    always_comb begin
        if (i_cmd.data.drive_torque > TQ_MAX) begin
            n_a_torque = TQ_W'(TQ_MAX);
        end else if (i_cmd.data.drive_torque < TQ_MIN) begin
            n_a_torque = TQ_W'(TQ_MIN);
        end else begin
            n_a_torque = TQ_W'(i_cmd.data.drive_torque);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en_a) begin
            r_a_vld <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_cmd.valid) begin
            r_a_req    <= i_cmd.data.req_type;
            r_a_torque <= n_a_torque;
            r_a_prod   <= PROD_W'(i_cmd.data.shaft_angle) * PROD_W'(r_pole_count);
            r_a_brake  <= i_cmd.data.brake_hold;
            r_a_swap   <= i_cmd.data.swap_phases;
            r_a_widx   <= i_cmd.data.table_index;
            r_a_wdata  <= i_cmd.data.table_entry;
        end
    end

    // Stage B: electrical index, direction shift and the three phase addresses.
    logic [ADDR_W-1:0]      n_b_base;
    logic signed [TQ_W-1:0] n_b_torque;
    logic [ADDR_W-1:0]      ta;

    assign ta = r_a_prod[ANGLE_SHIFT +: ADDR_W];

    always_comb begin
        if (r_a_brake) begin
            n_b_base   = '0;
            n_b_torque = r_a_torque;
        end else if (r_a_torque >= 0) begin
            n_b_base   = ADDR_W'(ta + ADDR_W'(SHIFT_BACK));
            n_b_torque = r_a_torque;
        end else begin
            n_b_base   = ADDR_W'(ta + ADDR_W'(SHIFT_FWD));
            n_b_torque = -r_a_torque;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en_b) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && r_a_vld) begin
            r_b_req    <= r_a_req;
            r_b_torque <= n_b_torque;
            r_b_swap   <= r_a_swap;
            r_b_widx   <= r_a_widx;
            r_b_wdata  <= r_a_wdata;
            r_b_addr_a <= n_b_base;
            r_b_addr_b <= ADDR_W'(n_b_base + ADDR_W'(THIRD));
            r_b_addr_c <= ADDR_W'(n_b_base + ADDR_W'(TWO_THIRDS));
        end
    end

    // Stage C: store writes land here, commutation words read all three phases.
    logic                 store_we;
    logic [ENTRY_W-1:0]   rd_a, rd_b, rd_c;

    assign store_we = en_c && r_b_vld && (r_b_req == REQ_WRITE)
                      && (ADDR_W'(r_b_widx) < TABLE_SIZE);

    scp_sine_ram u_ram_a (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_b_widx),
        .i_wdata (r_b_wdata),
        .i_re    (en_c),
        .i_raddr (r_b_addr_a),
        .o_rdata (rd_a)
    );

    scp_sine_ram u_ram_b (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_b_widx),
        .i_wdata (r_b_wdata),
        .i_re    (en_c),
        .i_raddr (r_b_addr_b),
        .o_rdata (rd_b)
    );

    scp_sine_ram u_ram_c (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_b_widx),
        .i_wdata (r_b_wdata),
        .i_re    (en_c),
        .i_raddr (r_b_addr_c),
        .o_rdata (rd_c)
    );

    // A write word ends here and gives no result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en_c) begin
            r_c_vld <= r_b_vld && (r_b_req == REQ_COMMUTATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c && r_b_vld) begin
            r_c_torque <= r_b_torque;
            r_c_swap   <= r_b_swap;
        end
    end

    // Stage D: scale, clip and order the phases into the output register.
    logic [DUTY_W-1:0] duty_a, duty_b, duty_c;

    assign duty_a = scale_duty(rd_a, r_c_torque);
    assign duty_b = scale_duty(rd_b, r_c_torque);
    assign duty_c = scale_duty(rd_c, r_c_torque);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en_d) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d && r_c_vld) begin
            r_d_duty.phase_one_duty   <= r_c_swap ? duty_b : duty_a;
            r_d_duty.phase_two_duty   <= r_c_swap ? duty_a : duty_b;
            r_d_duty.phase_three_duty <= duty_c;
        end
    end

    assign o_duty.valid = r_d_vld;
    assign o_duty.data  = r_d_duty;

    // A store write that moves on never becomes a result.
    `SCP_ASSERT_NEXT(a_write_no_result, i_clk, i_rst_n,
        (en_c && r_b_vld && (r_b_req == REQ_WRITE)), (!r_c_vld))

    // Braking always points the first phase at table entry zero.
    `SCP_ASSERT_NEXT(a_brake_index_zero, i_clk, i_rst_n,
        (en_b && r_a_vld && (r_a_req == REQ_COMMUTATE) && r_a_brake),
        (r_b_addr_a == '0))

    // A non-positive scaling torque drives all three phases to zero.
    `SCP_ASSERT_NEXT(a_no_torque_zero_duty, i_clk, i_rst_n,
        (en_d && r_c_vld && (r_c_torque <= 0)),
        (o_duty.data.phase_one_duty == '0 && o_duty.data.phase_two_duty == '0
         && o_duty.data.phase_three_duty == '0))

endmodule

### bench/sine_commutation_pwm_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sine commutation PWM block.
// Depends on scp_pkg, the scp_cmd_if and scp_duty_if interfaces and the block itself.

module sine_commutation_pwm_tb;
    import scp_pkg::*;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 250000;
    localparam int PHASES           = 7;
    localparam int RANDOM_PER_PHASE = 205;
    localparam int QUARTER3         = (3 * TABLE_SIZE) / 4;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [POLE_W-1:0] i_cfg_data;

    scp_cmd_if  cmd_if ();
    scp_duty_if duty_if ();

    sine_commutation_pwm DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_duty     (duty_if)
    );

    // Mirror of the block state and the queues between stimulus and checking.
    logic [ENTRY_W-1:0] sine_mirror [TABLE_SIZE];
    logic [POLE_W-1:0]  pole_setting;
    t_cmd               cmd_pending [$];
    t_duty              duty_expected [$];

    int error_count;
    int store_writes;
    int commutations;
    int duties_checked;
    int cycle_count;

    // Clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Clipped torque times one store entry, scaled back by the sine peak.
    function automatic logic [DUTY_W-1:0] scaled_duty(input int entry, input int torque);
        int prod;
        prod = (entry * torque) / SINE_PEAK;
        if (prod < 0) begin
            return '0;
        end
        if (prod > PWM_FULL - 1) begin
            return DUTY_W'(PWM_FULL - 1);
        end
        return DUTY_W'(prod);
    endfunction

    // Expected phase duties of one commutation word.
    function automatic t_duty predict_duties(input t_cmd c);
        int    torque;
        int    elec;
        t_duty d;
        logic [DUTY_W-1:0] da, db, dc;
        torque = int'($signed(c.drive_torque));
        if (torque > PWM_FULL) begin
            torque = PWM_FULL;
        end else if (torque < -PWM_FULL) begin
            torque = -PWM_FULL;
        end
        elec = (int'(c.shaft_angle) * int'(pole_setting) * TABLE_SIZE)
               / (2 * ENCODER_COUNTS);
        elec = elec % TABLE_SIZE;
        // Brake keeps the signed torque; otherwise the quarter shift follows the sign.
        if (c.brake_hold) begin
            elec = 0;
        end else if (torque >= 0) begin
            elec = (elec + TABLE_SIZE - QUARTER3) % TABLE_SIZE;
        end else begin
            torque = -torque;
            elec   = (elec + QUARTER3) % TABLE_SIZE;
        end
        da = scaled_duty(sine_mirror[elec], torque);
        db = scaled_duty(sine_mirror[(elec + TABLE_SIZE / 3) % TABLE_SIZE], torque);
        dc = scaled_duty(sine_mirror[(elec + 2 * (TABLE_SIZE / 3)) % TABLE_SIZE], torque);
        d.phase_one_duty   = c.swap_phases ? db : da;
        d.phase_two_duty   = c.swap_phases ? da : db;
        d.phase_three_duty = dc;
        return d;
    endfunction

    // Applies an accepted word to the mirror or queues its expected duties.
    task automatic accept_command(input t_cmd c);
        if (c.req_type == REQ_WRITE) begin
            if (int'(c.table_index) < TABLE_SIZE) begin
                sine_mirror[c.table_index] = c.table_entry;
            end
            store_writes++;
        end else begin
            duty_expected.push_back(predict_duties(c));
            commutations++;
        end
    endtask

    function automatic t_cmd commute_cmd(input int torque, input int angle,
                                         input bit brake, input bit swap);
        t_cmd c;
        c.req_type     = REQ_COMMUTATE;
        c.drive_torque = TORQUE_IN_W'(torque);
        c.shaft_angle  = ANGLE_W'(angle);
        c.brake_hold   = brake;
        c.swap_phases  = swap;
        c.table_index  = ADDR_W'($urandom_range(0, TABLE_SIZE - 1));
        c.table_entry  = ENTRY_W'($urandom_range(0, SINE_PEAK));
        return c;
    endfunction

    function automatic t_cmd store_cmd(input int index, input int entry);
        t_cmd c;
        c              = commute_cmd($urandom_range(0, 65535), $urandom_range(0, 4095),
                                     $urandom_range(0, 1), $urandom_range(0, 1));
        c.req_type     = REQ_WRITE;
        c.table_index  = ADDR_W'(index);
        c.table_entry  = ENTRY_W'(entry);
        return c;
    endfunction

    // Random word: mostly commutations, torque often near or beyond the clip points.
    function automatic t_cmd random_cmd();
        int torque;
        int entry;
        case ($urandom_range(0, 3))
            0: torque = $urandom_range(0, 65535);
            1: torque = $urandom_range(0, 2200) - 1100;
            2: torque = $urandom_range(0, 2048) - 1024;
            default: begin
                case ($urandom_range(0, 6))
                    0: torque = -32768;
                    1: torque = 32767;
                    2: torque = -PWM_FULL;
                    3: torque = PWM_FULL;
                    4: torque = -1;
                    5: torque = 1;
                    default: torque = 0;
                endcase
            end
        endcase
        entry = ($urandom_range(0, 15) == 0) ? SINE_PEAK : $urandom_range(0, SINE_PEAK);
        if ($urandom_range(0, 9) == 0) begin
            return store_cmd($urandom_range(0, TABLE_SIZE - 1), entry);
        end
        return commute_cmd(torque, $urandom_range(0, 4095),
                           $urandom_range(0, 7) == 0, $urandom_range(0, 1));
    endfunction

    // Returns once nothing is queued, in flight or awaited, plus a settling pause.
    task automatic wait_idle();
        @(posedge i_clk);
        while (cmd_pending.size() != 0 || cmd_if.valid || duty_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pole_count(input logic [POLE_W-1:0] value);
        wait_idle();
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        pole_setting = value;
    endtask

    // Command driver: one word per load, a random gap after each accepted word.
    int send_gap;
    int loaded_count;
    bit tx_quiet;
    bit drain_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            send_gap     = 0;
            loaded_count = 0;
            tx_quiet     = 1'b0;
            drain_hold   = 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                accept_command(cmd_if.data);
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (drain_hold && duty_expected.size() != 0) begin
                    cmd_if.valid <= 1'b0;
                end else if (cmd_pending.size() != 0) begin
                    cmd_if.data  <= cmd_pending.pop_front();
                    cmd_if.valid <= 1'b1;
                    if (loaded_count % 64 == 0) begin
                        tx_quiet = ($urandom_range(0, 3) == 0);
                    end
                    send_gap   = tx_quiet ? 0 : $urandom_range(0, 7);
                    drain_hold = (loaded_count % 113 == 112);
                    loaded_count++;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Duty monitor: checks each accepted word against the oldest expectation.
    int rx_stall;
    bit rx_quiet;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            duty_if.ready <= 1'b0;
            rx_stall      = 0;
            rx_quiet      = 1'b0;
        end else begin
            if (duty_if.valid && duty_if.ready) begin
                if (duty_expected.size() == 0) begin
                    $error("Duty word with no expectation waiting: %h", duty_if.data);
                    error_count++;
                end else begin
                    t_duty want;
                    want = duty_expected.pop_front();
                    if (duty_if.data.phase_one_duty !== want.phase_one_duty) begin
                        $error("phase_one_duty: expected %0d, actual %0d",
                               want.phase_one_duty, duty_if.data.phase_one_duty);
                        error_count++;
                    end
                    if (duty_if.data.phase_two_duty !== want.phase_two_duty) begin
                        $error("phase_two_duty: expected %0d, actual %0d",
                               want.phase_two_duty, duty_if.data.phase_two_duty);
                        error_count++;
                    end
                    if (duty_if.data.phase_three_duty !== want.phase_three_duty) begin
                        $error("phase_three_duty: expected %0d, actual %0d",
                               want.phase_three_duty, duty_if.data.phase_three_duty);
                        error_count++;
                    end
                end
                duties_checked++;
                if (duties_checked % 64 == 0) begin
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                duty_if.ready <= 1'b0;
            end else begin
                duty_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d duty words still awaited",
                     cycle_count, duty_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus: store fill and directed words, then random words over several pole counts.
    initial begin
        logic [POLE_W-1:0] pole_plan [PHASES];
        string             poles_seen;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.data    = '0;
        duty_if.ready  = 1'b0;
        pole_setting   = POLE_RESET;
        error_count    = 0;
        store_writes   = 0;
        commutations   = 0;
        duties_checked = 0;
        cycle_count    = 0;
        poles_seen     = "";
        pole_plan = '{POLE_RESET, 7'd2, 7'd64, 7'd0, 7'd1, 7'd127,
                      POLE_W'($urandom_range(3, 63))};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                write_pole_count(pole_plan[p]);
            end
            poles_seen = $sformatf("%s %0d", poles_seen, pole_plan[p]);
            @(negedge i_clk);
            if (p == 0) begin
                // Every entry is written before the first commutation reads the store.
                for (int i = 0; i < TABLE_SIZE; i++) begin
                    cmd_pending.push_back(store_cmd(i,
                        int'(512.0 + 512.0 * $sin(2.0 * 3.14159265358979 * i / TABLE_SIZE))));
                end
                // Torque extremes, clip points, both signs, brake and swap.
                cmd_pending.push_back(commute_cmd(0, 0, 1'b0, 1'b0));
                cmd_pending.push_back(commute_cmd(32767, 4095, 1'b0, 1'b0));
                cmd_pending.push_back(commute_cmd(-32768, 4095, 1'b0, 1'b1));
                cmd_pending.push_back(commute_cmd(PWM_FULL, 1234, 1'b0, 1'b0));
                cmd_pending.push_back(commute_cmd(-PWM_FULL, 2048, 1'b0, 1'b1));
                cmd_pending.push_back(commute_cmd(PWM_FULL - 1, 100, 1'b0, 1'b0));
                cmd_pending.push_back(commute_cmd(-1, 3000, 1'b0, 1'b0));
                cmd_pending.push_back(commute_cmd(1, 585, 1'b0, 1'b1));
                cmd_pending.push_back(commute_cmd(-PWM_FULL - 1, 4000, 1'b0, 1'b0));
                cmd_pending.push_back(commute_cmd(PWM_FULL + 1, 17, 1'b0, 1'b1));
                // Brake with positive torque, then with negative torque where all duties are 0.
                cmd_pending.push_back(commute_cmd(700, 777, 1'b1, 1'b0));
                cmd_pending.push_back(commute_cmd(-700, 777, 1'b1, 1'b1));
                cmd_pending.push_back(commute_cmd(-32768, 0, 1'b1, 1'b0));
                // Overwrite the brake entries with the value extremes and the midpoint and read them straight back.
                cmd_pending.push_back(store_cmd(0, SINE_PEAK));
                cmd_pending.push_back(store_cmd(TABLE_SIZE / 3, 0));
                cmd_pending.push_back(store_cmd(2 * (TABLE_SIZE / 3), SINE_PEAK / 2));
                cmd_pending.push_back(commute_cmd(PWM_FULL, 0, 1'b1, 1'b0));
                cmd_pending.push_back(commute_cmd(PWM_FULL, 0, 1'b1, 1'b1));
                cmd_pending.push_back(store_cmd(TABLE_SIZE - 1, SINE_PEAK));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                cmd_pending.push_back(random_cmd());
            end
        end

        wait_idle();
        $display("Covered %0d store writes and %0d commutations, %0d duty words checked,",
                 store_writes, commutations, duties_checked);
        $display("with pole counts%s and random stalls on both channels.", poles_seen);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/scp_pkg.sv
rtl/scp_cmd_if.sv
rtl/scp_duty_if.sv
rtl/scp_sine_ram.sv
rtl/sine_commutation_pwm.sv
bench/sine_commutation_pwm_tb.sv
